[hdl/dpt_pkg.sv]
`default_nettype none

package dpt_pkg;

  // Divider period in machine cycles.
  localparam int unsigned DivPeriod = 64;

  // Default width of the timer phase accumulator.
  localparam int unsigned PhaseWidthDefault = 16;

  // Clock cycles per machine cycle, as a left shift.
  localparam int unsigned McycleShift = 2;

  // Width of the longest timer period.
  localparam int unsigned PeriodWidth = 11;

  // Timer count that signals an overflow after an increment.
  localparam logic [7:0] WrapValue = 8'h00;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgTimerEnable = 2'd0,
    CfgClockSelect = 2'd1,
    CfgReloadValue = 2'd2
  } cfg_idx_e;

  // Configuration register contents.
  typedef struct packed {
    logic       enable;
    logic [1:0] clock_select;
    logic [7:0] reload;
  } dpt_cfg_t;

  // Timer period in clock cycles for a clock select code.
  function automatic logic [PeriodWidth-1:0] timer_period(input logic [1:0] sel);
    logic [PeriodWidth-1:0] period;
    case (sel)
      2'd0:    period = 11'd1024;
      2'd1:    period = 11'd16;
      2'd2:    period = 11'd64;
      default: period = 11'd256;
    endcase
    return period;
  endfunction

endpackage

`default_nettype wire

[hdl/dpt_div_step.sv]
`default_nettype none

module dpt_div_step (
  input  wire logic [7:0] phase_q_i,
  input  wire logic [7:0] count_q_i,
  input  wire logic [3:0] cycles_i,
  output logic      [7:0] phase_d_o,
  output logic      [7:0] count_d_o
);
  import dpt_pkg::*;

  logic [8:0] sum;
  logic [7:0] sum_sat;

  // Add the new cycles and saturate at the phase width.
  assign sum     = {1'b0, phase_q_i} + {5'b0, cycles_i};
  assign sum_sat = sum[8] ? 8'hFF : sum[7:0];

  // Take off one period at most and advance the divider count.
  always_comb begin
    if (sum_sat >= 8'(DivPeriod)) begin
      phase_d_o = sum_sat - 8'(DivPeriod);
      count_d_o = count_q_i + 8'd1;
    end else begin
      phase_d_o = sum_sat;
      count_d_o = count_q_i;
    end
  end

endmodule

`default_nettype wire

[hdl/dpt_tmr_step.sv]
`default_nettype none

module dpt_tmr_step #(
  parameter int unsigned PhaseWidth = dpt_pkg::PhaseWidthDefault
) (
  input  wire dpt_pkg::dpt_cfg_t          cfg_i,
  input  wire logic [PhaseWidth-1:0]      phase_q_i,
  input  wire logic [7:0]                 count_q_i,
  input  wire logic [3:0]                 cycles_i,
  output logic      [PhaseWidth-1:0]      phase_d_o,
  output logic      [7:0]                 count_d_o,
  output logic                            irq_o
);
  import dpt_pkg::*;

  localparam int unsigned SumW = PhaseWidth + 1;

  logic [SumW-1:0]       sum;
  logic [PhaseWidth-1:0] sum_sat;
  logic [PhaseWidth-1:0] period;
  logic [7:0]            next_count;

  // Clock cycles are machine cycles shifted up; saturate at the phase width.
  assign sum     = SumW'(phase_q_i) + (SumW'(cycles_i) << McycleShift);
  assign sum_sat = sum[SumW-1] ? {PhaseWidth{1'b1}} : sum[PhaseWidth-1:0];
  assign period  = PhaseWidth'(timer_period(cfg_i.clock_select));

  assign next_count = count_q_i + 8'd1;

  // One period at most per request; reload and flag the interrupt on overflow.
  always_comb begin
    phase_d_o = phase_q_i;
    count_d_o = count_q_i;
    irq_o     = 1'b0;
    if (cfg_i.enable) begin
      phase_d_o = sum_sat;
      if (sum_sat >= period) begin
        phase_d_o = sum_sat - period;
        if (next_count == WrapValue) begin
          count_d_o = cfg_i.reload;
          irq_o     = 1'b1;
        end else begin
          count_d_o = next_count;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/divider_and_prescaled_timer.sv]
// Free-running divider and prescaled 8-bit timer, advanced once per request.
// Input channel (in_valid_i / in_ready_o) carries elapsed_cycles_i, the machine
// cycles of one finished instruction. Output channel (out_valid_o / out_ready_i)
// returns one result per request: divider_value_o, timer_value_o and
// timer_irq_o, the latter high when the timer overflowed and was reloaded.
// Configuration writes come on cfg_valid_i / cfg_ready_o with cfg_index_i
// (0 timer_enable, 1 clock_select, 2 reload_value) and cfg_data_i; index 3 is
// ignored. cfg_ready_o is always high.
// The result is registered and appears in the cycle after a request is taken.
// Throughput is one request per cycle when unstalled, set by the single result
// register; the update itself is one add, saturate and compare per counter.
// When the receiver stalls, the result holds and in_ready_o drops until the
// result is taken; a new request is taken in the same cycle a result leaves.
// Reset clears all phases, counts and configuration registers and leaves the
// output channel empty.
`default_nettype none

module divider_and_prescaled_timer #(
  parameter int unsigned PHASE_WIDTH = dpt_pkg::PhaseWidthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [3:0] elapsed_cycles_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] divider_value_o,
  output logic      [7:0] timer_value_o,
  output logic            timer_irq_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  import dpt_pkg::*;

  dpt_cfg_t               cfg_q;
  logic [7:0]             div_phase_q, div_phase_d;
  logic [7:0]             div_count_q, div_count_d;
  logic [PHASE_WIDTH-1:0] tmr_phase_q, tmr_phase_d;
  logic [7:0]             tmr_count_q, tmr_count_d;
  logic                   tmr_irq;
  logic                   out_valid_q;
  logic                   irq_q;
  logic                   accept;

  // Handshakes: a request goes in whenever the result slot is free or leaving.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgTimerEnable: cfg_q.enable       <= cfg_data_i[0];
        CfgClockSelect: cfg_q.clock_select <= cfg_data_i[1:0];
        CfgReloadValue: cfg_q.reload       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next divider state.
  dpt_div_step u_div_step (
    .phase_q_i (div_phase_q),
    .count_q_i (div_count_q),
    .cycles_i  (elapsed_cycles_i),
    .phase_d_o (div_phase_d),
    .count_d_o (div_count_d)
  );

  // Next timer state.
  dpt_tmr_step #(
    .PhaseWidth (PHASE_WIDTH)
  ) u_tmr_step (
    .cfg_i     (cfg_q),
    .phase_q_i (tmr_phase_q),
    .count_q_i (tmr_count_q),
    .cycles_i  (elapsed_cycles_i),
    .phase_d_o (tmr_phase_d),
    .count_d_o (tmr_count_d),
    .irq_o     (tmr_irq)
  );

  // Counter state; the counts double as the result payload, since they
  // change only when a new result is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_phase_q <= '0;
      div_count_q <= '0;
      tmr_phase_q <= '0;
      tmr_count_q <= '0;
      irq_q       <= 1'b0;
    end else if (accept) begin
      div_phase_q <= div_phase_d;
      div_count_q <= div_count_d;
      tmr_phase_q <= tmr_phase_d;
      tmr_count_q <= tmr_count_d;
      irq_q       <= tmr_irq;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign divider_value_o = div_count_q;
  assign timer_value_o   = tmr_count_q;
  assign timer_irq_o     = irq_q;

  // A disabled timer never moves its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_q.enable) |=> $stable(tmr_count_q))
    else $error("timer count moved while the timer was disabled");

  // An overflow shows the reload value with the interrupt flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tmr_irq) |=> (timer_irq_o && timer_value_o == $past(cfg_q.reload)))
    else $error("timer overflow did not reload the timer");

  // The divider advances by at most one per request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (div_count_q == $past(div_count_q) ||
                div_count_q == $past(div_count_q) + 8'd1))
    else $error("divider advanced by more than one");

endmodule

`default_nettype wire
